FILE: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Shared widths, register indexes, constants and control types of the
// speed PI controller.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int WINDOW_MAX_DEF = 128;

  localparam int DELTA_W    = 8;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 15;
  localparam int VEL_W      = 16;
  localparam int CMD_W      = 15;
  localparam int LEN_CFG_W  = 8;
  localparam int INTEG_W    = 24;
  localparam int ERR_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd5;

  localparam int VEL_SHIFT = 4;
  localparam int CMD_SHIFT = 5;
  localparam int CMD_LIMIT = 8192;
  localparam logic [CMD_W-1:0] CMD_NEUTRAL = 15'd16384;

  // Step strobes from the sequencer to the datapath units.
  typedef struct packed {
    logic rd;
    logic update;
    logic vel_mul;
    logic err_calc;
    logic p_mul;
    logic i_mul;
    logic finish;
  } spc_ctrl_t;

endpackage

FILE: rtl/spc_if.sv
// ----------------------------------------------------------------------------
// spc_if
// Valid/ready stream interfaces for the pulse input and the command output.
// ----------------------------------------------------------------------------
interface spc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [spc_pkg::DELTA_W-1:0]  pulse_delta;

  modport source(output valid, output pulse_delta, input ready);
  modport sink(input valid, input pulse_delta, output ready);
endinterface

interface spc_out_if;
  logic                               valid;
  logic                               ready;
  logic [spc_pkg::CMD_W-1:0]          esc_command;
  logic signed [spc_pkg::VEL_W-1:0]   velocity;
  logic [spc_pkg::SPEED_W-1:0]        velocity_setpoint;
  logic                               at_limit;

  modport source(output valid, output esc_command, output velocity,
                 output velocity_setpoint, output at_limit, input ready);
  modport sink(input valid, input esc_command, input velocity,
               input velocity_setpoint, input at_limit, output ready);
endinterface

FILE: rtl/spc_ram.sv
// ----------------------------------------------------------------------------
// spc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/spc_window.sv
// ----------------------------------------------------------------------------
// spc_window
// Circular window of recent pulse deltas held in RAM, with its running sum.
// ----------------------------------------------------------------------------
module spc_window #(
  parameter int WINDOW_MAX = spc_pkg::WINDOW_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  spc_pkg::spc_ctrl_t                    ctrl,
  input  logic signed [spc_pkg::DELTA_W-1:0]    pulse_delta,
  input  logic                                  len_we,
  input  logic [spc_pkg::LEN_CFG_W-1:0]         len_value,
  output logic signed [spc_pkg::DELTA_W+$clog2(WINDOW_MAX):0] sum
);

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int LEN_W = PTR_W + 1;
  localparam int SUM_W = spc_pkg::DELTA_W + PTR_W + 1;

  logic [LEN_W-1:0]                   len;
  logic [LEN_W-1:0]                   fill;
  logic [PTR_W-1:0]                   ptr;
  logic [PTR_W-1:0]                   cur_ptr;
  logic [PTR_W-1:0]                   rd_ptr;
  logic [LEN_W-1:0]                   ptr_inc;
  logic signed [spc_pkg::DELTA_W-1:0] delta_q;
  logic [spc_pkg::DELTA_W-1:0]        rdata;
  logic signed [spc_pkg::DELTA_W-1:0] old_val;

  // The store is written in order from entry zero after every clear, so an
  // entry below the fill count holds a delta and any other reads as zero.
  assign rd_ptr  = ({1'b0, ptr} >= len) ? '0 : ptr;
  assign old_val = ({1'b0, cur_ptr} < fill) ? signed'(rdata) : '0;
  assign ptr_inc = {1'b0, cur_ptr} + LEN_W'(1);

  spc_ram #(
    .WIDTH(spc_pkg::DELTA_W),
    .DEPTH(WINDOW_MAX)
  ) u_store (
    .clk  (clk),
    .we   (ctrl.update),
    .waddr(cur_ptr),
    .wdata(delta_q),
    .re   (ctrl.rd),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= LEN_W'(1);
      fill <= '0;
      ptr  <= '0;
      sum  <= '0;
    end else if (len_we) begin
      if (len_value == '0) begin
        len <= LEN_W'(1);
      end else if (32'(len_value) > WINDOW_MAX) begin
        len <= LEN_W'(WINDOW_MAX);
      end else begin
        len <= LEN_W'(len_value);
      end
      fill <= '0;
      ptr  <= '0;
      sum  <= '0;
    end else if (ctrl.update) begin
      sum <= sum - SUM_W'(old_val) + SUM_W'(delta_q);
      ptr <= (ptr_inc >= len) ? '0 : ptr_inc[PTR_W-1:0];
      if ({1'b0, cur_ptr} == fill) begin
        fill <= fill + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      cur_ptr <= rd_ptr;
      delta_q <= pulse_delta;
    end
  end

endmodule

FILE: rtl/spc_pi.sv
// ----------------------------------------------------------------------------
// spc_pi
// Velocity scaling, setpoint rate limit and clamped PI law on one shared
// multiplier, with integrator anti-windup.
// ----------------------------------------------------------------------------
module spc_pi #(
  parameter int WINDOW_MAX = spc_pkg::WINDOW_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  spc_pkg::spc_ctrl_t                    ctrl,
  input  logic signed [spc_pkg::DELTA_W+$clog2(WINDOW_MAX):0] sum,
  input  logic [spc_pkg::GAIN_W-1:0]            prop_gain,
  input  logic [spc_pkg::GAIN_W-1:0]            int_gain,
  input  logic [spc_pkg::SPEED_W-1:0]           target_speed,
  input  logic [spc_pkg::SPEED_W-1:0]           rate_step,
  input  logic [spc_pkg::GAIN_W-1:0]            velocity_scale,
  output logic [spc_pkg::CMD_W-1:0]             esc_command,
  output logic signed [spc_pkg::VEL_W-1:0]      velocity,
  output logic [spc_pkg::SPEED_W-1:0]           velocity_setpoint,
  output logic                                  at_limit
);

  localparam int SUM_W  = spc_pkg::DELTA_W + $clog2(WINDOW_MAX) + 1;
  localparam int MA_W0  = (SUM_W > spc_pkg::INTEG_W) ? SUM_W : spc_pkg::INTEG_W;
  localparam int MA_W   = (MA_W0 > spc_pkg::ERR_W) ? MA_W0 : spc_pkg::ERR_W;
  localparam int MB_W   = spc_pkg::GAIN_W + 1;
  localparam int PW     = MA_W + MB_W;
  localparam int RAW_W  = PW + 1;
  localparam int IS_W   = spc_pkg::INTEG_W + 1;
  localparam int DIFF_W = spc_pkg::SPEED_W + 2;
  localparam int CV_W   = spc_pkg::CMD_W - 1;

  localparam logic signed [PW-1:0]    VEL_HI = PW'(2 ** (spc_pkg::VEL_W - 1) - 1);
  localparam logic signed [PW-1:0]    VEL_LO = PW'(-(2 ** (spc_pkg::VEL_W - 1)));
  localparam logic signed [IS_W-1:0]  INT_HI = IS_W'(2 ** (spc_pkg::INTEG_W - 1) - 1);
  localparam logic signed [IS_W-1:0]  INT_LO = IS_W'(-(2 ** (spc_pkg::INTEG_W - 1)));
  localparam logic signed [RAW_W-1:0] RAW_HI =
    RAW_W'(spc_pkg::CMD_LIMIT * (2 ** spc_pkg::CMD_SHIFT));

  logic                                started;
  logic [spc_pkg::SPEED_W-1:0]         last_sp;
  logic signed [spc_pkg::INTEG_W-1:0]  integrator;
  logic signed [spc_pkg::INTEG_W-1:0]  integ_new;
  logic signed [spc_pkg::ERR_W-1:0]    err_q;
  logic signed [PW-1:0]                prod;
  logic signed [PW-1:0]                acc;

  logic signed [MA_W-1:0]              mul_a;
  logic signed [MB_W-1:0]              mul_b;
  logic signed [PW-1:0]                mul_p;

  logic [spc_pkg::SPEED_W-1:0]         prev_sp;
  logic signed [DIFF_W-1:0]            diff;
  logic signed [DIFF_W-1:0]            rate_s;
  logic [spc_pkg::SPEED_W-1:0]         sp_next;

  logic signed [PW-1:0]                vel_shift;
  logic signed [spc_pkg::VEL_W-1:0]    vel_sat;
  logic signed [spc_pkg::ERR_W-1:0]    err;
  logic signed [IS_W-1:0]              integ_sum;
  logic signed [spc_pkg::INTEG_W-1:0]  integ_sat;

  logic signed [RAW_W-1:0]             cmd_raw;
  logic                                lim_lo;
  logic                                lim_hi;
  logic [CV_W-1:0]                     cmd_val;

  // Shared multiplier: velocity scaling, then the P term, then the I term.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctrl.vel_mul) begin
      mul_a = MA_W'(sum);
      mul_b = {1'b0, velocity_scale};
    end else if (ctrl.p_mul) begin
      mul_a = MA_W'(err_q);
      mul_b = {1'b0, prop_gain};
    end else if (ctrl.i_mul) begin
      mul_a = MA_W'(integ_new);
      mul_b = {1'b0, int_gain};
    end
  end

  assign mul_p = mul_a * mul_b;

  // Setpoint rate limit. On the first tick the previous setpoint is half
  // the target.
  always_comb begin
    prev_sp = started ? last_sp : (target_speed >> 1);
    diff    = signed'({2'b00, target_speed}) - signed'({2'b00, prev_sp});
    rate_s  = signed'({2'b00, rate_step});
    if (diff > rate_s) begin
      sp_next = prev_sp + rate_step;
    end else if (-diff > rate_s) begin
      sp_next = prev_sp - rate_step;
    end else begin
      sp_next = target_speed;
    end
  end

  // Arithmetic shift floors the scaled product, then it saturates to Q4.12.
  always_comb begin
    vel_shift = prod >>> spc_pkg::VEL_SHIFT;
    if (vel_shift > VEL_HI) begin
      vel_sat = spc_pkg::VEL_W'(VEL_HI);
    end else if (vel_shift < VEL_LO) begin
      vel_sat = spc_pkg::VEL_W'(VEL_LO);
    end else begin
      vel_sat = vel_shift[spc_pkg::VEL_W-1:0];
    end
    err       = signed'({3'b000, velocity_setpoint}) - spc_pkg::ERR_W'(vel_sat);
    integ_sum = IS_W'(integrator) + IS_W'(err);
    if (integ_sum > INT_HI) begin
      integ_sat = spc_pkg::INTEG_W'(INT_HI);
    end else if (integ_sum < INT_LO) begin
      integ_sat = spc_pkg::INTEG_W'(INT_LO);
    end else begin
      integ_sat = integ_sum[spc_pkg::INTEG_W-1:0];
    end
  end

  // Command clamp to 0..0.25 with 20 fraction bits, then down to Q0.15.
  always_comb begin
    cmd_raw = RAW_W'(acc) + RAW_W'(prod);
    lim_lo  = cmd_raw[RAW_W-1];
    lim_hi  = cmd_raw > RAW_HI;
    if (lim_lo) begin
      cmd_val = '0;
    end else if (lim_hi) begin
      cmd_val = CV_W'(spc_pkg::CMD_LIMIT);
    end else begin
      cmd_val = cmd_raw[spc_pkg::CMD_SHIFT +: CV_W];
    end
    esc_command = spc_pkg::CMD_NEUTRAL + {1'b0, cmd_val};
    at_limit    = lim_lo | lim_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      last_sp    <= '0;
      integrator <= '0;
    end else begin
      if (ctrl.vel_mul) begin
        started <= 1'b1;
        last_sp <= sp_next;
      end
      // The tick's integrator step is dropped when the command clamps and the integral gain is nonzero.
      if (ctrl.finish && !(at_limit && int_gain != '0)) begin
        integrator <= integ_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.vel_mul || ctrl.p_mul || ctrl.i_mul) begin
      prod <= mul_p;
    end
    if (ctrl.i_mul) begin
      acc <= prod;
    end
    if (ctrl.vel_mul) begin
      velocity_setpoint <= sp_next;
    end
    if (ctrl.err_calc) begin
      velocity  <= vel_sat;
      err_q     <= err;
      integ_new <= integ_sat;
    end
  end

endmodule

FILE: rtl/speed_pi_controller.sv
// ----------------------------------------------------------------------------
// speed_pi_controller
// Encoder speed loop: windowed velocity estimate, rate-limited setpoint and
// clamped PI command with anti-windup.
// ----------------------------------------------------------------------------
// Each input transfer is one control tick and yields one output transfer.
// The sequencer takes one tick at a time: a read of the delta window RAM,
// its write-back with the running-sum update, then three passes of one
// shared multiplier (velocity scale, proportional term, integral term)
// with the error and integrator step after the first, and the final clamp.
// A result waiting in the output register stalls a tick only at its last step.
// A write of window_length empties the window at once, with no clearing pass.
// Configuration must be written only while no tick is in flight; the block
// itself does not enforce it.
module speed_pi_controller #(
  parameter int WINDOW_MAX = spc_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  spc_in_if.sink                            in_ch,
  spc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SUM_W = spc_pkg::DELTA_W + $clog2(WINDOW_MAX) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_VEL  = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;
  localparam logic [2:0] S_PMUL = 3'd4;
  localparam logic [2:0] S_IMUL = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  spc_pkg::spc_ctrl_t            ctrl;
  logic                          out_free;

  logic [spc_pkg::GAIN_W-1:0]    prop_gain;
  logic [spc_pkg::GAIN_W-1:0]    int_gain;
  logic [spc_pkg::SPEED_W-1:0]   target_speed;
  logic [spc_pkg::SPEED_W-1:0]   rate_step;
  logic [spc_pkg::GAIN_W-1:0]    velocity_scale;
  logic                          len_we;

  logic signed [SUM_W-1:0]       sum;
  logic [spc_pkg::CMD_W-1:0]     pi_cmd;
  logic signed [spc_pkg::VEL_W-1:0] pi_vel;
  logic [spc_pkg::SPEED_W-1:0]   pi_sp;
  logic                          pi_limit;

  logic                          out_valid;

  assign in_ch.ready = (state == S_IDLE);
  assign out_free    = !out_valid || out_ch.ready;
  assign len_we      = cfg_we && (cfg_index == spc_pkg::REG_WINDOW_LENGTH);

  always_comb begin
    ctrl          = '0;
    ctrl.rd       = (state == S_IDLE) && in_ch.valid;
    ctrl.update   = (state == S_SUM);
    ctrl.vel_mul  = (state == S_VEL);
    ctrl.err_calc = (state == S_ERR);
    ctrl.p_mul    = (state == S_PMUL);
    ctrl.i_mul    = (state == S_IMUL);
    ctrl.finish   = (state == S_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_ch.valid) state_next = S_SUM;
      S_SUM:   state_next = S_VEL;
      S_VEL:   state_next = S_ERR;
      S_ERR:   state_next = S_PMUL;
      S_PMUL:  state_next = S_IMUL;
      S_IMUL:  state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain      <= '0;
      int_gain       <= '0;
      target_speed   <= '0;
      rate_step      <= '0;
      velocity_scale <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spc_pkg::REG_PROP_GAIN:      prop_gain      <= cfg_data;
        spc_pkg::REG_INT_GAIN:       int_gain       <= cfg_data;
        spc_pkg::REG_TARGET_SPEED:   target_speed   <= cfg_data[spc_pkg::SPEED_W-1:0];
        spc_pkg::REG_RATE_STEP:      rate_step      <= cfg_data[spc_pkg::SPEED_W-1:0];
        spc_pkg::REG_VELOCITY_SCALE: velocity_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  spc_window #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .pulse_delta(in_ch.pulse_delta),
    .len_we     (len_we),
    .len_value  (cfg_data[spc_pkg::LEN_CFG_W-1:0]),
    .sum        (sum)
  );

  spc_pi #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_pi (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .sum              (sum),
    .prop_gain        (prop_gain),
    .int_gain         (int_gain),
    .target_speed     (target_speed),
    .rate_step        (rate_step),
    .velocity_scale   (velocity_scale),
    .esc_command      (pi_cmd),
    .velocity         (pi_vel),
    .velocity_setpoint(pi_sp),
    .at_limit         (pi_limit)
  );

  // Output register: loaded on the last step, held until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      out_ch.esc_command       <= pi_cmd;
      out_ch.velocity          <= pi_vel;
      out_ch.velocity_setpoint <= pi_sp;
      out_ch.at_limit          <= pi_limit;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
